// ----- design/csc_pkg.sv -----
`timescale 1ns / 1ps
package csc_pkg;

    // Angle path: residual angle is signed Q2.29, held in 32 bits
    localparam int ANGLE_IN_W = 31;
    localparam int ANGLE_W    = 32;
    localparam int OUT_W      = 32;

    // Table length caps the number of rotation cells
    localparam int TABLE_LEN = 40;

    // pi/2 in Q2.29
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q29 = 32'sd843314857;

    // Final scaling: value in Q2.30 times gain in Q1.30
    localparam int Q_W    = 33;
    localparam int GAIN_W = 31;
    localparam int PROD_W = Q_W + GAIN_W;
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
    localparam logic signed [PROD_W-1:0] ROUND_Q30 = 64'sd536870912;
    localparam logic signed [PROD_W-1:0] ONE_Q30   = 64'sd1073741824;

    // atan(2^-i) in Q2.29, rounded to nearest
    localparam logic signed [ANGLE_W-1:0] ATAN_Q29 [TABLE_LEN] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64,
        32'sd32,        32'sd16,        32'sd8,         32'sd4,
        32'sd2,         32'sd1,         32'sd0,         32'sd0,
        32'sd0,         32'sd0,         32'sd0,         32'sd0,
        32'sd0,         32'sd0,         32'sd0,         32'sd0
    };

endpackage

// ----- design/csc_cell.sv -----
`timescale 1ns / 1ps
module csc_cell
    import csc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int STAGE      = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [DATA_WIDTH-1:0] i_x,
    input  logic signed [DATA_WIDTH-1:0] i_y,
    input  logic signed [ANGLE_W-1:0]    i_z,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_x,
    output logic signed [DATA_WIDTH-1:0] o_y,
    output logic signed [ANGLE_W-1:0]    o_z
);

    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] r_x;
    logic signed [DATA_WIDTH-1:0] r_y;
    logic signed [ANGLE_W-1:0]    r_z;
    logic signed [DATA_WIDTH-1:0] xs;
    logic signed [DATA_WIDTH-1:0] ys;
    logic                         z_neg;

    // Arithmetic shifts by this cell's iteration index
    assign xs    = i_x >>> STAGE;
    assign ys    = i_y >>> STAGE;
    assign z_neg = i_z[ANGLE_W-1];

    // Valid travels with the data; cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // One micro-rotation; sign of residual angle picks direction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (z_neg) begin
                r_x <= i_x + ys;
                r_y <= i_y - xs;
                r_z <= i_z + ATAN_Q29[STAGE];
            end else begin
                r_x <= i_x - ys;
                r_y <= i_y + xs;
                r_z <= i_z - ATAN_Q29[STAGE];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ----- design/csc_scale.sv -----
`timescale 1ns / 1ps
module csc_scale
    import csc_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic signed [OUT_W-1:0]      o_result
);

    localparam int SHIFT = (DATA_WIDTH > 32) ? DATA_WIDTH - 32 : 32 - DATA_WIDTH;

    logic signed [Q_W-1:0]    q;
    logic signed [Q_W-1:0]    r_q;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] shifted;

    // Bring the value to Q2.30
    generate
        if (DATA_WIDTH > 32) begin : g_down
            localparam logic signed [DATA_WIDTH:0] HALF =
                (DATA_WIDTH+1)'(1) << (SHIFT - 1);
            logic signed [DATA_WIDTH:0] sum;
            logic signed [DATA_WIDTH:0] sum_sh;
            // round half up, then arithmetic shift
            assign sum    = $signed({i_value[DATA_WIDTH-1], i_value}) + HALF;
            assign sum_sh = sum >>> SHIFT;
            assign q      = sum_sh[Q_W-1:0];
        end else begin : g_up
            assign q = Q_W'(i_value) <<< SHIFT;
        end
    endgenerate

    // Gain multiply, registered on both sides
    assign prod = r_q * GAIN_Q30;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= q;
            r_prod <= prod;
        end
    end

    // Round to Q1.30 and clamp to [-1, 1]
    assign rounded = r_prod + ROUND_Q30;
    assign shifted = rounded >>> 30;

    always_comb begin
        priority if (shifted > ONE_Q30) begin
            o_result = ONE_Q30[OUT_W-1:0];
        end else if (shifted < -ONE_Q30) begin
            o_result = OUT_W'(-ONE_Q30);
        end else begin
            o_result = shifted[OUT_W-1:0];
        end
    end

endmodule

// ----- design/cordic_sin_cos_core.sv -----
`timescale 1ns / 1ps
// Rotation-mode CORDIC sine/cosine. Each transaction carries one angle in
// radians (signed Q2.29), saturated to +/-pi/2, and returns its cosine and
// sine (signed Q1.30, clamped to +/-1.0). The datapath is a chain of
// min(ITERATIONS, 40) shift-add rotation cells, one per iteration, followed
// by a two-register gain multiply, so one new angle is taken every clock
// cycle while o_stall is low, and each result passes through the input
// register, one register per cell, two scaling registers and the output
// register. A two-entry output buffer absorbs downstream stall: the chain
// freezes only when both entries are full, and o_stall is then raised.
module cordic_sin_cos_core
    import csc_pkg::*;
#(
    parameter int ITERATIONS = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ANGLE_IN_W-1:0] i_angle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [OUT_W-1:0]      o_cosine,
    output logic signed [OUT_W-1:0]      o_sine
);

    localparam int N = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
    localparam logic signed [DATA_WIDTH-1:0] X_START =
        DATA_WIDTH'(1) << (DATA_WIDTH - 2);

    logic                         en;
    logic signed [ANGLE_W-1:0]    angle_ext;
    logic signed [ANGLE_W-1:0]    angle_sat;
    logic                         r_v0;
    logic signed [ANGLE_W-1:0]    r_z0;
    logic                         cv [N+1];
    logic signed [DATA_WIDTH-1:0] cx [N+1];
    logic signed [DATA_WIDTH-1:0] cy [N+1];
    logic signed [ANGLE_W-1:0]    cz [N+1];
    logic [1:0]                   r_sv;
    logic signed [OUT_W-1:0]      res_cos;
    logic signed [OUT_W-1:0]      res_sin;
    logic                         r_out_valid;
    logic signed [OUT_W-1:0]      r_out_cos;
    logic signed [OUT_W-1:0]      r_out_sin;
    logic                         r_skid_valid;
    logic signed [OUT_W-1:0]      r_skid_cos;
    logic signed [OUT_W-1:0]      r_skid_sin;
    logic                         out_free;
    logic                         pipe_out;

    // Whole chain advances unless the skid entry is occupied
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // Input saturation to +/-pi/2
    assign angle_ext = ANGLE_W'(i_angle);
    always_comb begin
        priority if (angle_ext > HALF_PI_Q29) begin
            angle_sat = HALF_PI_Q29;
        end else if (angle_ext < -HALF_PI_Q29) begin
            angle_sat = -HALF_PI_Q29;
        end else begin
            angle_sat = angle_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z0 <= angle_sat;
        end
    end

    // Rotation chain, starting from (1, 0)
    assign cv[0] = r_v0;
    assign cx[0] = X_START;
    assign cy[0] = '0;
    assign cz[0] = r_z0;

    generate
        for (genvar i = 0; i < N; i++) begin : g_cell
            csc_cell #(
                .DATA_WIDTH(DATA_WIDTH),
                .STAGE     (i)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_valid(cv[i]),
                .i_x    (cx[i]),
                .i_y    (cy[i]),
                .i_z    (cz[i]),
                .o_valid(cv[i+1]),
                .o_x    (cx[i+1]),
                .o_y    (cy[i+1]),
                .o_z    (cz[i+1])
            );
        end
    endgenerate

    // Gain scaling, two register stages
    csc_scale #(.DATA_WIDTH(DATA_WIDTH)) u_scale_cos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (cx[N]),
        .o_result(res_cos)
    );

    csc_scale #(.DATA_WIDTH(DATA_WIDTH)) u_scale_sin (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (cy[N]),
        .o_result(res_sin)
    );

    // Valid alongside the scaling stages (final residual angle unused)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (en) begin
            r_sv <= {r_sv[0], cv[N]};
        end
    end

    assign pipe_out = en && r_sv[1];
    assign out_free = !r_out_valid || !i_stall;

    // Output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= pipe_out;
            end
        end else if (pipe_out) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_cos <= r_skid_cos;
                r_out_sin <= r_skid_sin;
            end else begin
                r_out_cos <= res_cos;
                r_out_sin <= res_sin;
            end
        end else if (pipe_out) begin
            r_skid_cos <= res_cos;
            r_skid_sin <= res_sin;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_cosine = r_out_cos;
    assign o_sine   = r_out_sin;

endmodule

// ----- design/csc_checker.sv -----
`timescale 1ns / 1ps
module csc_checker
    import csc_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic signed [ANGLE_IN_W-1:0] i_angle,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [OUT_W-1:0]      o_cosine,
    input logic signed [OUT_W-1:0]      o_sine
);

    localparam logic signed [OUT_W-1:0] ONE = 32'sd1073741824;

    // A stalled input transaction stays offered with the same angle
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_angle))
        else $error("input transaction changed while stalled");

    // A stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Results stay within [-1, 1] in Q1.30
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cosine <= ONE) && (o_cosine >= -ONE)
                    && (o_sine <= ONE) && (o_sine >= -ONE))
        else $error("result outside unit range");

    // Input back-pressure only follows a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // Back-pressure clears once the held result is taken
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && o_valid && !i_stall |=> !o_stall)
        else $error("input stall held after result taken");

endmodule

bind cordic_sin_cos_core csc_checker u_csc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_angle (i_angle),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_cosine(o_cosine),
    .o_sine  (o_sine)
);
